// ----- src/varint_length_prefixed_deframer_unit_assert.svh -----
// Assertion macros for the varint deframer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_UNIT_ASSERT_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/vlpd_pkg.sv -----
// Shared types and constants for the varint length-prefixed deframer.
// Used by vlpd_decode, the top level and both bench modules; no dependencies.
package vlpd_pkg;

  localparam int unsigned VarintLimitDefault = 32;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned AccumW = 32;
  localparam int unsigned IdentW = 31;
  localparam int unsigned IdCountW = 3;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_IDENT   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DROP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    logic [IdentW-1:0] packet_ident;
    logic              first;
    logic              last;
  } result_t;

endpackage

// ----- src/varint_length_prefixed_deframer_unit.sv -----
// Top level of the varint length-prefixed packet deframer.
// Instantiates vlpd_decode; uses vlpd_pkg and the assertion macro header.
`include "varint_length_prefixed_deframer_unit_assert.svh"

// Takes one stream byte per beat and returns payload bytes tagged with their packet id and
// first/last marks, one result per empty packet, and a single error result when framing
// breaks, after which all bytes are swallowed until reset. A byte is taken every cycle
// while results drain: it sits in the input register while the decoder handles it, and
// its result is then loaded into the output register. A two-entry output stage (result
// register plus skid register) absorbs a decoder result while the output stalls; once the
// skid register is full and a byte waits in the input register, the stall backs up to the
// input.
module varint_length_prefixed_deframer_unit #(
  parameter int unsigned VARINT_LIMIT_BITS = vlpd_pkg::VarintLimitDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  payload_byte,
  output logic [vlpd_pkg::IdentW-1:0] packet_ident,
  output logic                        first_of_packet,
  output logic                        last_of_packet
);
  import vlpd_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       skid_valid;
  result_t    skid;
  result_t    out_q;
  logic       out_valid_q;

  logic       in_take;
  logic       proc;
  logic       out_take;
  logic       dec_valid;
  result_t    dec_res;
  logic       dec_fault;

  assign in_stall = byte_valid && skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign proc     = byte_valid && !skid_valid;
  assign out_take = out_valid_q && !out_stall;

  vlpd_decode #(
    .VARINT_LIMIT_BITS(VARINT_LIMIT_BITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (proc),
    .data_byte (byte_q),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_take) begin
      byte_valid <= 1'b1;
    end else if (proc) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_q <= data_byte;
    end
  end

  // The skid register only fills while the result register is held, and it always
  // drains into the result register before a new decoder result goes there.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid) begin
        out_valid_q <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        out_valid_q <= proc && dec_valid;
      end
    end else if (proc && dec_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid) begin
        out_q <= skid;
      end else if (proc && dec_valid) begin
        out_q <= dec_res;
      end
    end else if (proc && dec_valid) begin
      skid <= dec_res;
    end
  end

  assign out_valid       = out_valid_q;
  assign kind            = out_q.kind;
  assign payload_byte    = out_q.payload_byte;
  assign packet_ident    = out_q.packet_ident;
  assign first_of_packet = out_q.first;
  assign last_of_packet  = out_q.last;

  assign dec_fault = proc && dec_valid && (dec_res.kind == KIND_LONG || dec_res.kind == KIND_BAD);

  `VLPD_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid_q, "skid full with output empty")
  `VLPD_ASSERT_NEXT(a_silent_after_error, dec_fault, !dec_valid, "result after a framing error")
  `VLPD_ASSERT_SAME(a_first_on_data, out_valid_q && out_q.first, out_q.kind == KIND_DATA, "stray first")

endmodule

// ----- src/vlpd_decode.sv -----
// Framing state machine of the deframer: varint decode, length tracking, result build.
// Depends on vlpd_pkg.
module vlpd_decode #(
  parameter int unsigned VARINT_LIMIT_BITS = vlpd_pkg::VarintLimitDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  output logic              res_valid,
  output vlpd_pkg::result_t res
);
  import vlpd_pkg::*;

  localparam int unsigned ShiftW = $clog2(VARINT_LIMIT_BITS);

  phase_t              phase, phase_next;
  logic [AccumW-1:0]   varint_accum, varint_accum_next;
  logic [ShiftW-1:0]   shift_position, shift_position_next;
  logic [IdentW-1:0]   bytes_remaining, bytes_remaining_next;
  logic [IdCountW-1:0] id_byte_count, id_byte_count_next;
  logic [IdentW-1:0]   current_ident, current_ident_next;
  logic                first_pending, first_pending_next;

  logic [AccumW-1:0]   acc_or;
  logic [ShiftW:0]     shift_add;
  logic                cont;
  logic                too_long;
  logic [IdCountW-1:0] id_count_inc;
  logic [IdentW-1:0]   rem_after_id;
  logic                last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LENGTH;
      varint_accum    <= '0;
      shift_position  <= '0;
      bytes_remaining <= '0;
      id_byte_count   <= '0;
      current_ident   <= '0;
      first_pending   <= 1'b1;
    end else if (step) begin
      phase           <= phase_next;
      varint_accum    <= varint_accum_next;
      shift_position  <= shift_position_next;
      bytes_remaining <= bytes_remaining_next;
      id_byte_count   <= id_byte_count_next;
      current_ident   <= current_ident_next;
      first_pending   <= first_pending_next;
    end
  end

  // Bits of a group that land at bit 32 or above fall off the top of the accumulator.
  assign acc_or       = varint_accum | (AccumW'(data_byte[GroupBits-1:0]) << shift_position);
  assign shift_add    = {1'b0, shift_position} + (ShiftW+1)'(GroupBits);
  assign cont         = data_byte[7];
  assign too_long     = cont && (shift_add >= (ShiftW+1)'(VARINT_LIMIT_BITS));
  assign id_count_inc = id_byte_count + IdCountW'(1);
  assign rem_after_id = bytes_remaining - IdentW'(id_count_inc);
  assign last_byte    = (bytes_remaining <= IdentW'(1));

  always_comb begin
    phase_next           = phase;
    varint_accum_next    = varint_accum;
    shift_position_next  = shift_position;
    bytes_remaining_next = bytes_remaining;
    id_byte_count_next   = id_byte_count;
    current_ident_next   = current_ident;
    first_pending_next   = first_pending;
    res_valid            = 1'b0;
    res                  = '0;
    res.kind             = KIND_DATA;

    case (phase)
      PH_LENGTH: begin
        varint_accum_next = acc_or;
        if (cont) begin
          if (too_long) begin
            phase_next = PH_DROP;
            res_valid  = 1'b1;
            res.kind   = KIND_LONG;
          end else begin
            shift_position_next = shift_add[ShiftW-1:0];
          end
        end else if (acc_or == '0 || acc_or[AccumW-1]) begin
          // A length read as a signed word must be positive.
          phase_next = PH_DROP;
          res_valid  = 1'b1;
          res.kind   = KIND_BAD;
        end else begin
          bytes_remaining_next = acc_or[IdentW-1:0];
          varint_accum_next    = '0;
          shift_position_next  = '0;
          id_byte_count_next   = '0;
          phase_next           = PH_IDENT;
        end
      end
      PH_IDENT: begin
        id_byte_count_next = id_count_inc;
        varint_accum_next  = acc_or;
        if (cont) begin
          if (too_long) begin
            phase_next = PH_DROP;
            res_valid  = 1'b1;
            res.kind   = KIND_LONG;
          end else begin
            shift_position_next = shift_add[ShiftW-1:0];
          end
        end else if (acc_or[AccumW-1] || (IdentW'(id_count_inc) > bytes_remaining)) begin
          phase_next = PH_DROP;
          res_valid  = 1'b1;
          res.kind   = KIND_BAD;
        end else begin
          current_ident_next   = acc_or[IdentW-1:0];
          bytes_remaining_next = rem_after_id;
          varint_accum_next    = '0;
          shift_position_next  = '0;
          id_byte_count_next   = '0;
          first_pending_next   = 1'b1;
          if (rem_after_id == '0) begin
            // The id used up the whole length: report an empty packet.
            phase_next       = PH_LENGTH;
            res_valid        = 1'b1;
            res.kind         = KIND_EMPTY;
            res.packet_ident = acc_or[IdentW-1:0];
            res.last         = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.payload_byte   = data_byte;
        res.packet_ident   = current_ident;
        res.first          = first_pending;
        res.last           = last_byte;
        first_pending_next = 1'b0;
        if (last_byte) begin
          bytes_remaining_next = '0;
          phase_next           = PH_LENGTH;
          first_pending_next   = 1'b1;
          varint_accum_next    = '0;
          shift_position_next  = '0;
        end else begin
          bytes_remaining_next = bytes_remaining - IdentW'(1);
        end
      end
      PH_DROP: begin
        // Framing is lost; every byte is discarded until reset.
      end
      default: begin
        phase_next = PH_DROP;
      end
    endcase
  end

endmodule

// ----- bench/varint_deframer_scoreboard.sv -----
// Scoreboard for the varint length-prefixed deframer: watches both channels,
// decodes every accepted input beat itself and compares each output beat.
// Depends on vlpd_pkg for the phase, kind and result types.
module varint_deframer_scoreboard (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  kind,
  input  logic [7:0]                  payload_byte,
  input  logic [vlpd_pkg::IdentW-1:0] packet_ident,
  input  logic                        first_of_packet,
  input  logic                        last_of_packet,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vlpd_pkg::*;

  typedef enum int {GROUP_MORE, GROUP_DONE, GROUP_OVERFLOW} group_step_t;

  phase_t            dec_phase;
  logic [AccumW-1:0] acc;
  int unsigned       grp_shift;
  logic [31:0]       remain;
  int unsigned       id_count;
  logic [IdentW-1:0] cur_ident;
  logic              first_due;
  result_t           results_due[$];

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Folds one 7-bit group into the varint; bits past bit 31 fall off.
  function automatic group_step_t absorb_group(input logic [7:0] b);
    logic [63:0] wide;
    wide = 64'(b[6:0]) << grp_shift;
    acc = acc | wide[AccumW-1:0];
    if (!b[7]) return GROUP_DONE;
    grp_shift += GroupBits;
    if (grp_shift >= VarintLimitDefault) return GROUP_OVERFLOW;
    return GROUP_MORE;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    result_t     r;
    logic        produced;
    group_step_t step;
    produced = 1'b0;
    r = '0;
    case (dec_phase)
      PH_LENGTH: begin
        step = absorb_group(b);
        if (step == GROUP_OVERFLOW) begin
          dec_phase = PH_DROP;
          r.kind = KIND_LONG;
          produced = 1'b1;
        end else if (step == GROUP_DONE) begin
          if (acc == '0 || acc[31]) begin
            dec_phase = PH_DROP;
            r.kind = KIND_BAD;
            produced = 1'b1;
          end else begin
            remain = acc;
            acc = '0;
            grp_shift = 0;
            id_count = 0;
            dec_phase = PH_IDENT;
          end
        end
      end
      PH_IDENT: begin
        id_count = (id_count + 1) & 7;
        step = absorb_group(b);
        if (step == GROUP_OVERFLOW) begin
          dec_phase = PH_DROP;
          r.kind = KIND_LONG;
          produced = 1'b1;
        end else if (step == GROUP_DONE) begin
          if (acc[31] || id_count > remain) begin
            dec_phase = PH_DROP;
            r.kind = KIND_BAD;
            produced = 1'b1;
          end else begin
            cur_ident = acc[IdentW-1:0];
            remain = remain - id_count;
            acc = '0;
            grp_shift = 0;
            id_count = 0;
            first_due = 1'b1;
            if (remain == 0) begin
              // The id used up the whole length: the packet has no payload.
              dec_phase = PH_LENGTH;
              r.kind = KIND_EMPTY;
              r.packet_ident = cur_ident;
              r.last = 1'b1;
              produced = 1'b1;
            end else begin
              dec_phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        r.kind = KIND_DATA;
        r.payload_byte = b;
        r.packet_ident = cur_ident;
        r.first = first_due;
        r.last = (remain <= 1);
        produced = 1'b1;
        first_due = 1'b0;
        if (r.last) begin
          remain = 0;
          dec_phase = PH_LENGTH;
          first_due = 1'b1;
          acc = '0;
          grp_shift = 0;
        end else begin
          remain = remain - 1;
        end
      end
      default: ;
    endcase
    if (produced) results_due = {results_due, r};
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      dec_phase = PH_LENGTH;
      acc = '0;
      grp_shift = 0;
      remain = 0;
      id_count = 0;
      cur_ident = '0;
      first_due = 1'b1;
      results_due.delete();
    end else begin
      // The output beat is checked first; its expectation is always older than
      // anything predicted from an input beat at the same edge.
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report($sformatf("output beat with nothing expected, kind %0d", kind));
        end else begin
          want = results_due.pop_front();
          if (kind !== want.kind)
            report($sformatf("kind got %0d want %0d", kind, want.kind));
          if (payload_byte !== want.payload_byte)
            report($sformatf("payload_byte got %0h want %0h", payload_byte,
                             want.payload_byte));
          if (packet_ident !== want.packet_ident)
            report($sformatf("packet_ident got %0h want %0h", packet_ident,
                             want.packet_ident));
          if (first_of_packet !== want.first)
            report($sformatf("first_of_packet got %0b want %0b", first_of_packet,
                             want.first));
          if (last_of_packet !== want.last)
            report($sformatf("last_of_packet got %0b want %0b", last_of_packet,
                             want.last));
        end
      end
      if (in_valid && !in_stall) deframe_byte(data_byte);
    end
    pending <= results_due.size();
  end

endmodule

// ----- bench/varint_length_prefixed_deframer_unit_tb.sv -----
// Stimulus and verdict for the varint length-prefixed deframer.
// Instantiates the block and varint_deframer_scoreboard; uses vlpd_pkg widths.
module varint_length_prefixed_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500_000;
  localparam int TargetBeats = 600;

  typedef enum int {
    END_LENGTH_OVERRUN,
    END_LENGTH_ZERO,
    END_LENGTH_NEGATIVE,
    END_IDENT_NEGATIVE,
    END_IDENT_OVERLONG,
    END_IDENT_OVERRUN,
    END_NOISE
  } ending_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    data_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    kind;
  logic [7:0]                    payload_byte;
  logic [vlpd_pkg::IdentW-1:0]   packet_ident;
  logic                          first_of_packet;
  logic                          last_of_packet;
  int                            mismatches;
  int                            pending_results;
  int                            cycle_count = 0;
  int                            beats_sent = 0;
  logic                          calm = 1'b0;

  varint_length_prefixed_deframer_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .packet_ident    (packet_ident),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet)
  );

  varint_deframer_scoreboard u_scoreboard (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .packet_ident    (packet_ident),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .mismatches      (mismatches),
    .pending         (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("varint_length_prefixed_deframer_unit: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all while calm is set.
  function automatic int idle_span();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    forever begin
      hold = idle_span();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  function automatic int varint_span(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // Sends v in nbytes groups; a fifth group carries random bits above bit 31,
  // which the decoder must discard.
  task automatic send_varint(input logic [31:0] v, input int nbytes);
    logic [34:0] ext;
    ext = {3'($urandom_range(0, 7)), v};
    for (int i = 0; i < nbytes; i++)
      send_byte({1'(i < nbytes - 1), ext[7 * i +: 7]});
  endtask

  task automatic send_packet(input logic [30:0] ident, input int id_len,
                             input int body_len);
    logic [31:0] total;
    int          len_len;
    total = id_len + body_len;
    len_len = varint_span(total);
    if ($urandom_range(0, 3) == 0) len_len += $urandom_range(0, 5 - len_len);
    send_varint(total, len_len);
    send_varint({1'b0, ident}, id_len);
    repeat (body_len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    logic [30:0] ident;
    int          id_len;
    int          body_len;
    int          pick;
    logic        paused;
    ending_t     ending;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty packet: the id alone fills the length.
    send_byte(8'h01);
    send_byte(8'h00);
    // Widest legal id with a single all-ones payload byte.
    send_varint(32'd6, 1);
    send_varint(32'h7FFF_FFFF, 5);
    send_byte(8'hFF);
    // Length padded out to five groups, zero payload byte.
    send_varint(32'd2, 5);
    send_varint(32'h7F, 1);
    send_byte(8'h00);
    // Padded id followed by a three-beat payload.
    send_varint(32'd8, 1);
    send_varint(32'd1, 5);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h00);

    while (beats_sent < TargetBeats) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (!paused && beats_sent >= TargetBeats / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) ident = 31'($urandom_range(0, 127));
      else if (pick < 6) ident = 31'($urandom_range(128, (1 << 21) - 1));
      else if (pick == 6) ident = 31'h7FFF_FFFF;
      else if (pick == 7) ident = '0;
      else ident = 31'($urandom);
      id_len = varint_span({1'b0, ident});
      if ($urandom_range(0, 3) == 0) id_len += $urandom_range(0, 5 - id_len);
      pick = $urandom_range(0, 9);
      if (pick < 2) body_len = 0;
      else if (pick < 8) body_len = $urandom_range(1, 8);
      else if (pick == 8) body_len = $urandom_range(9, 40);
      else body_len = $urandom_range(128, 200);
      send_packet(ident, id_len, body_len);
    end

    // The run closes on one framing fault, after which every later byte is dropped, or on noise.
    calm = 1'b0;
    ending = ending_t'($urandom_range(0, 6));
    case (ending)
      END_LENGTH_OVERRUN: repeat (5) send_byte({1'b1, 7'($urandom)});
      END_LENGTH_ZERO:    send_varint(32'd0, $urandom_range(1, 5));
      END_LENGTH_NEGATIVE: send_varint({1'b1, 31'($urandom)}, 5);
      END_IDENT_NEGATIVE: begin
        send_varint(32'($urandom_range(5, 9)), 1);
        send_varint({1'b1, 31'($urandom)}, 5);
      end
      END_IDENT_OVERLONG: begin
        body_len = $urandom_range(1, 4);
        send_varint(32'(body_len), 1);
        send_varint(32'($urandom_range(0, 127)), $urandom_range(body_len + 1, 5));
      end
      END_IDENT_OVERRUN: begin
        send_varint(32'($urandom_range(6, 100)), 1);
        repeat (5) send_byte({1'b1, 7'($urandom)});
      end
      default: repeat (24) send_byte(8'($urandom));
    endcase
    repeat ($urandom_range(8, 24)) send_byte(8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("varint_length_prefixed_deframer_unit: match");
    end else begin
      $display("varint_length_prefixed_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule
